@@ hdl/pearson_correlation_stream_core_defines.svh @@
// assertion macros for the pearson correlation stream core
`ifndef PEARSON_CORRELATION_STREAM_CORE_DEFINES_SVH
`define PEARSON_CORRELATION_STREAM_CORE_DEFINES_SVH
// property that must hold on every clock edge outside reset
`define PCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// property that must hold on every clock edge, reset included
`define PCS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

@@ hdl/pcs_pkg.sv @@
// shared types and constants for the pearson correlation stream core
package pcs_pkg;
  localparam int MaxPairs = 1024;
  localparam int SampleBits = 16;
  localparam int CntW = 11;
  localparam int SumW = 26;
  localparam int SqW = 42;
  localparam int QDepth = 2;

  typedef struct packed {
    logic signed [15:0] sample_a;
    logic signed [15:0] sample_b;
    logic last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] correlation;
    logic degenerate;
    logic [10:0] pair_count;
  } out_item_t;

  // finished run handed from the accumulator to the solver
  typedef struct packed {
    logic [CntW-1:0] n;
    logic [SumW-1:0] sa;
    logic [SumW-1:0] sb;
    logic [SqW-1:0] saa;
    logic [SqW-1:0] sbb;
    logic [SqW-1:0] sab;
  } run_sums_t;

  typedef enum logic [3:0] {
    S_IDLE, S_NS, S_NSW, S_SSW, S_VAR, S_PW, S_N2W, S_NORM, S_SRCH, S_SQW, S_CMP, S_DONE
  } solve_state_t;
endpackage

@@ hdl/pcs_accum.sv @@
// front part: accumulates sums of one run and hands the totals on
module pcs_accum import pcs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  item,
  input  logic      take,
  output logic      run_valid,
  output run_sums_t run_sums
);
  logic [CntW-1:0] cnt;
  logic [SumW-1:0] sa, sb;
  logic [SqW-1:0]  saa, sbb, sab;
  logic signed [SampleBits-1:0] a, b;
  logic signed [2*SampleBits-1:0] paa, pbb, pab;
  logic room;

  assign a = item.sample_a[SampleBits-1:0];
  assign b = item.sample_b[SampleBits-1:0];
  assign paa = a * a;
  assign pbb = b * b;
  assign pab = a * b;
  assign room = cnt < CntW'(MaxPairs);

  always_comb begin
    run_sums.n = cnt;
    run_sums.sa = sa;
    run_sums.sb = sb;
    run_sums.saa = saa;
    run_sums.sbb = sbb;
    run_sums.sab = sab;
    if (room) begin
      run_sums.n = cnt + 1'b1;
      run_sums.sa = sa + SumW'(a);
      run_sums.sb = sb + SumW'(b);
      run_sums.saa = saa + SqW'(paa);
      run_sums.sbb = sbb + SqW'(pbb);
      run_sums.sab = sab + SqW'(pab);
    end
  end

  assign run_valid = take && item.last_sample;

  always_ff @(posedge clk) begin
    if (rst || run_valid) begin
      cnt <= '0; sa <= '0; sb <= '0; saa <= '0; sbb <= '0; sab <= '0;
    end else if (take) begin
      cnt <= run_sums.n; sa <= run_sums.sa; sb <= run_sums.sb;
      saa <= run_sums.saa; sbb <= run_sums.sbb; sab <= run_sums.sab;
    end
  end
endmodule

@@ hdl/pcs_fifo.sv @@
// small queue of finished runs between accumulator and solver
module pcs_fifo import pcs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr,
  input  run_sums_t wdata,
  output logic      full,
  input  logic      rd,
  output logic      empty,
  output run_sums_t rdata
);
  run_sums_t mem [QDepth];
  logic wp, rp;
  logic [1:0] fill;

  assign full = fill == 2'(QDepth);
  assign empty = fill == '0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; fill <= '0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      fill <= fill + 2'(wr) - 2'(rd);
    end
  end
endmodule

@@ hdl/pcs_solve.sv @@
// back part: forms the coefficient by sequential multiply and bit search
module pcs_solve import pcs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  run_sums_t in_sums,
  output logic      in_take,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      out_take
);
  solve_state_t state, state_next;
  run_sums_t s;
  logic mul_start, mul_busy, mul_done;
  logic [63:0] mul_a, mul_b, ma, mb, mp;
  logic [1:0] midx;
  logic [31:0] pa, pb;
  logic [63:0] part;
  logic [127:0] part_sh, prod;
  logic [63:0] num, va, vb, t1, nmag;
  logic [63:0] sa_x, sb_x, saa_x, sbb_x, sab_x;
  logic [127:0] p, n2;
  logic [15:0] q;
  logic [3:0] bitn;
  logic [15:0] cand;
  logic degen;
  logic [1:0] step;

  // 64x64 product built from four 32x32 partial products, one per cycle
  assign pa = midx[0] ? ma[63:32] : ma[31:0];
  assign pb = midx[1] ? mb[63:32] : mb[31:0];
  assign part = 64'(pa) * 64'(pb);

  always_comb begin
    case (midx) inside
      2'd0: part_sh = {64'd0, part};
      2'd1, 2'd2: part_sh = {32'd0, part, 32'd0};
      default: part_sh = {part, 64'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
      mul_done <= 1'b0;
    end else begin
      mul_done <= mul_busy && (midx == 2'd3);
      if (mul_start) mul_busy <= 1'b1;
      else if (midx == 2'd3) mul_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_start) begin
      ma <= mul_a;
      mb <= mul_b;
      midx <= '0;
      prod <= '0;
    end else if (mul_busy) begin
      prod <= prod + part_sh;
      midx <= midx + 2'd1;
    end
  end

  assign sa_x = {{(64-SumW){s.sa[SumW-1]}}, s.sa};
  assign sb_x = {{(64-SumW){s.sb[SumW-1]}}, s.sb};
  assign saa_x = {{(64-SqW){s.saa[SqW-1]}}, s.saa};
  assign sbb_x = {{(64-SqW){s.sbb[SqW-1]}}, s.sbb};
  assign sab_x = {{(64-SqW){s.sab[SqW-1]}}, s.sab};
  assign nmag = num[63] ? 64'd0 - num : num;
  assign cand = q | (16'd1 << bitn);
  assign mp = ({47'd0, cand, 1'b0} - 64'd1);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // three passes: cross, a, b terms; each n*S then S*S; then va*vb, num^2, search
  always_comb begin
    state_next = state;
    in_take = 1'b0;
    out_valid = state == S_DONE;
    mul_start = 1'b0;
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_IDLE: if (in_valid) begin
        in_take = 1'b1;
        state_next = S_NS;
      end
      S_NS: begin
        mul_start = 1'b1;
        mul_a = {{(64-CntW){1'b0}}, s.n};
        mul_b = (step == 2'd0) ? sab_x : (step == 2'd1) ? saa_x : sbb_x;
        state_next = S_NSW;
      end
      S_NSW: if (mul_done) begin
        mul_start = 1'b1;
        mul_a = (step == 2'd2) ? sb_x : sa_x;
        mul_b = (step == 2'd1) ? sa_x : sb_x;
        state_next = S_SSW;
      end
      S_SSW: if (mul_done) state_next = (step == 2'd2) ? S_VAR : S_NS;
      S_VAR: if ((va == '0) || (vb == '0)) begin
        state_next = S_DONE;
      end else begin
        mul_start = 1'b1;
        mul_a = va;
        mul_b = vb;
        state_next = S_PW;
      end
      S_PW: if (mul_done) begin
        mul_start = 1'b1;
        mul_a = nmag;
        mul_b = nmag;
        state_next = S_N2W;
      end
      S_N2W: if (mul_done) state_next = S_NORM;
      S_NORM: if (p[127:62] == '0) state_next = S_SRCH;
      S_SRCH: begin
        mul_start = 1'b1;
        mul_a = mp;
        mul_b = mp;
        state_next = S_SQW;
      end
      S_SQW: if (mul_done) begin
        mul_start = 1'b1;
        mul_a = prod[63:0];
        mul_b = p[63:0];
        state_next = S_CMP;
      end
      S_CMP: if (mul_done) state_next = (bitn == '0) ? S_DONE : S_SRCH;
      S_DONE: if (out_take) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        s <= in_sums;
        step <= '0;
        q <= '0;
        bitn <= 4'd15;
      end
      S_NSW: if (mul_done) t1 <= prod[63:0];
      S_SSW: if (mul_done) begin
        if (step == 2'd0) num <= t1 - prod[63:0];
        else if (step == 2'd1) va <= t1 - prod[63:0];
        else vb <= t1 - prod[63:0];
        step <= step + 2'd1;
      end
      S_VAR: degen <= (va == '0) || (vb == '0);
      S_PW: if (mul_done) p <= prod;
      S_N2W: if (mul_done) n2 <= prod;
      S_NORM: if (p[127:62] != '0) begin
        p <= p >> 1;
        n2 <= n2 >> 1;
      end
      S_CMP: if (mul_done) begin
        if (prod <= {n2[95:0], 32'd0}) q <= cand;
        bitn <= bitn - 4'd1;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_item.degenerate = degen;
    out_item.pair_count = s.n;
    if (degen) out_item.correlation = '0;
    else if (num[63]) out_item.correlation = 16'd0 - q;
    else out_item.correlation = q[15] ? 16'sd32767 : q;
  end
endmodule

@@ hdl/pearson_correlation_stream_core.sv @@
// pearson correlation stream core: one sample pair per cycle, coefficient per run
// throughput: one pair per cycle while the two-run queue has room; input stalls while the queue is full
// the solver uses one 32x32 multiplier, four partial products per 64x64 product, and a 16-step bit search
// synchronous active-high rst clears all sums and the run queue and returns the solver to idle
module pearson_correlation_stream_core import pcs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  logic      push,
  output logic      full,
  output out_item_t out_item,
  output logic      empty,
  input  logic      pop
);
  logic take, run_valid, q_empty, q_take, s_valid;
  run_sums_t run_sums, q_sums;

  assign take = push && !full;
  assign empty = !s_valid;

  pcs_accum u_accum (
    .clk, .rst, .item(in_item), .take, .run_valid, .run_sums
  );

  pcs_fifo u_fifo (
    .clk, .rst, .wr(run_valid), .wdata(run_sums), .full,
    .rd(q_take), .empty(q_empty), .rdata(q_sums)
  );

  pcs_solve u_solve (
    .clk, .rst, .in_valid(!q_empty), .in_sums(q_sums), .in_take(q_take),
    .out_valid(s_valid), .out_item, .out_take(pop)
  );
endmodule

@@ hdl/pcs_checker.sv @@
// port-level assertions for the pearson correlation stream core
`include "pearson_correlation_stream_core_defines.svh"
module pcs_checker import pcs_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      full,
  input logic      pop,
  input logic      empty,
  input out_item_t out_item
);
  `PCS_ASSERT(a_degen_zero, !empty && out_item.degenerate |-> out_item.correlation == '0, "degenerate result not zero")
  `PCS_ASSERT(a_count_nz, !empty |-> out_item.pair_count != '0, "zero pair count")
  `PCS_ASSERT(a_hold, !empty && !pop |=> !empty && $stable(out_item), "result changed before transfer")
  `PCS_ASSERT_ALWAYS(a_reset, $past(rst) |-> empty && !full, "not clear after reset")
endmodule

bind pearson_correlation_stream_core pcs_checker u_pcs_checker (
  .clk, .rst, .full, .pop, .empty, .out_item
);
